[rtl/core/pprk4_pkg.sv]
// Shared types, constants and micro-op decode for the predator-prey RK4 stepper.
package pprk4_pkg;

   // Signed internal word: stage states, derivatives, products, sums.
   localparam int DW      = 52;
   // Magnitude of an internal word.
   localparam int MW      = DW - 1;
   // Multiplier digit: the B magnitude is consumed in DIG_N digits, MSB first.
   localparam int DIG_W   = 17;
   localparam int DIG_N   = MW / DIG_W;
   localparam int ACC_W   = 2 * MW;
   // Divide-by-six unit retires one nibble per cycle.
   localparam int DIV_STEPS = DW / 4;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   // Internal saturation limit 2^47-1, and a wide limit used only for the final
   // increment (anything that large clamps the population anyway).
   localparam logic [MW-1:0] INT_LIM = MW'((64'd1 << 47) - 64'd1);
   localparam logic [MW-1:0] BIG_LIM = {MW{1'b1}};

   localparam logic [1:0] LAST_STAGE = 2'd3;
   localparam logic [2:0] LAST_OP    = 3'd6;

   // Configuration register indexes.
   localparam logic [2:0] REG_PREY_GROWTH   = 3'd0;
   localparam logic [2:0] REG_PREDATION     = 3'd1;
   localparam logic [2:0] REG_PREDATOR_GAIN = 3'd2;
   localparam logic [2:0] REG_PREDATOR_DEATH = 3'd3;
   localparam logic [2:0] REG_TIME_STEP     = 3'd4;
   localparam logic [2:0] REG_INITIAL_PREY  = 3'd5;
   localparam logic [2:0] REG_INITIAL_PRED  = 3'd6;

   localparam logic [31:0] RST_PREY_GROWTH    = 32'd6710886;
   localparam logic [31:0] RST_PREDATION      = 32'd16777;
   localparam logic [31:0] RST_PREDATOR_GAIN  = 32'd16777;
   localparam logic [31:0] RST_PREDATOR_DEATH = 32'd15099494;
   localparam logic [23:0] RST_TIME_STEP      = 24'd167772;
   localparam logic [31:0] RST_INITIAL_PREY   = 32'd32768000;
   localparam logic [31:0] RST_INITIAL_PRED   = 32'd32768000;

   typedef enum logic [3:0] {
      OPD_SR, OPD_SF, OPD_RF, OPD_KR, OPD_KF, OPD_SUMR, OPD_SUMF,
      OPD_CA, OPD_CB, OPD_CC, OPD_CD, OPD_DT
   } opnd_type;

   typedef enum logic [1:0] { SH_POP, SH_COEF, SH_HALF } shift_type;

   typedef enum logic [2:0] {
      DST_RF, DST_TMP, DST_KR, DST_KF, DST_SR, DST_SF, DST_INCR, DST_INCF
   } dst_type;

   typedef struct packed {
      opnd_type  a_sel;
      opnd_type  b_sel;
      shift_type shift;
      logic      big;     // use the wide limit
      dst_type   dst;
      logic      acc_r;   // fold kr into the prey sum
      logic      acc_f;   // fold kf into the predator sum
      logic      dbl;     // weight two for the fold
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_OPND, ST_MUL, ST_SAT, ST_WB, ST_DIV, ST_FIN
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       opnd;
      logic       mul;
      logic       mul_first;
      logic [1:0] dig;
      logic       sat;
      logic       wb;
      logic       div_step;
      logic       commit;
      uop_type    uop;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } stat_type;

   // One derivative evaluation (ops 0..4) and one stage update (ops 5..6).
   function automatic uop_type uop_decode(input logic [1:0] stage, input logic [2:0] op);
      uop_type u;
      logic    last;
      logic    mid;
      last = (stage == LAST_STAGE);
      mid  = (stage == 2'd1) || (stage == 2'd2);
      u = '{a_sel: OPD_SR, b_sel: OPD_SF, shift: SH_POP, big: 1'b0, dst: DST_RF,
            acc_r: 1'b0, acc_f: 1'b0, dbl: mid};
      unique case (op)
         3'd0: begin
            u.a_sel = OPD_SR; u.b_sel = OPD_SF; u.shift = SH_POP; u.dst = DST_RF;
         end
         3'd1: begin
            u.a_sel = OPD_CA; u.b_sel = OPD_SR; u.shift = SH_COEF; u.dst = DST_TMP;
         end
         3'd2: begin
            u.a_sel = OPD_CB; u.b_sel = OPD_RF; u.shift = SH_COEF; u.dst = DST_KR;
         end
         3'd3: begin
            u.a_sel = OPD_CC; u.b_sel = OPD_RF; u.shift = SH_COEF; u.dst = DST_TMP;
            u.acc_r = 1'b1;
         end
         3'd4: begin
            u.a_sel = OPD_CD; u.b_sel = OPD_SF; u.shift = SH_COEF; u.dst = DST_KF;
         end
         3'd5: begin
            u.a_sel = OPD_DT;
            u.acc_f = 1'b1;
            if (last) begin
               u.b_sel = OPD_SUMR; u.shift = SH_COEF; u.big = 1'b1; u.dst = DST_INCR;
            end else begin
               u.b_sel = OPD_KR; u.dst = DST_SR;
               u.shift = (stage == 2'd2) ? SH_COEF : SH_HALF;
            end
         end
         3'd6: begin
            u.a_sel = OPD_DT;
            if (last) begin
               u.b_sel = OPD_SUMF; u.shift = SH_COEF; u.big = 1'b1; u.dst = DST_INCF;
            end else begin
               u.b_sel = OPD_KF; u.dst = DST_SF;
               u.shift = (stage == 2'd2) ? SH_COEF : SH_HALF;
            end
         end
         default: begin
            u.dst = DST_RF;
         end
      endcase
      return u;
   endfunction

endpackage

[rtl/core/pprk4_ctrl.sv]
// Sequencer for the RK4 step: walks stages, micro-ops, multiplier digits and divide steps.
module pprk4_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pprk4_pkg::stat_type stat,
   output pprk4_pkg::cmd_type  cmd
);
   import pprk4_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         stage_ff, stage_in;
   logic [2:0]         op_ff, op_in;
   logic [1:0]         dig_ff, dig_in;
   logic [DIV_CW-1:0]  div_ff, div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= '0;
         op_ff    <= '0;
         dig_ff   <= '0;
         div_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         op_ff    <= op_in;
         dig_ff   <= dig_in;
         div_ff   <= div_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      op_in    = op_ff;
      dig_in   = dig_ff;
      div_in   = div_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            stage_in = '0;
            op_in    = '0;
            state_in = ST_OPND;
         end
         ST_OPND: begin
            dig_in   = 2'(DIG_N - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (dig_ff == '0) begin
               state_in = ST_SAT;
            end else begin
               dig_in = dig_ff - 2'd1;
            end
         end
         ST_SAT: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            if (op_ff == LAST_OP) begin
               op_in = '0;
               if (stage_ff == LAST_STAGE) begin
                  div_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  stage_in = stage_ff + 2'd1;
                  state_in = ST_OPND;
               end
            end else begin
               op_in    = op_ff + 3'd1;
               state_in = ST_OPND;
            end
         end
         ST_DIV: begin
            if (div_ff == DIV_CW'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               div_in = div_ff + DIV_CW'(1);
            end
         end
         ST_FIN: begin
            if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.uop       = uop_decode(stage_ff, op_ff);
      cmd.dig       = dig_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOAD: cmd.load = 1'b1;
         ST_OPND: cmd.opnd = 1'b1;
         ST_MUL: begin
            cmd.mul       = 1'b1;
            cmd.mul_first = (dig_ff == 2'(DIG_N - 1));
         end
         ST_SAT:  cmd.sat = 1'b1;
         ST_WB:   cmd.wb = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_FIN:  cmd.commit = !stat.rsp_busy;
         default: cmd.load = 1'b0;
      endcase
   end

endmodule

[rtl/core/pprk4_dpath.sv]
// Datapath: configuration, population state, shared digit multiplier, divide by six, result.
module pprk4_dpath #(
   parameter int POP_FRAC_BITS  = 16,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  pprk4_pkg::cmd_type  cmd,
   output pprk4_pkg::stat_type stat,
   input  logic                restart,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [31:0]         prey_now,
   output logic [31:0]         predator_now,
   output logic [31:0]         step_index,
   output logic                clipped
);
   import pprk4_pkg::*;

   localparam logic signed [DW:0] KLIM_P = $signed({2'b00, INT_LIM});
   localparam logic signed [DW:0] KLIM_N = -KLIM_P;
   localparam logic signed [DW:0] POP_TOP = $signed({{(DW-32){1'b0}}, 33'h0FFFFFFFF});

   // configuration
   logic [31:0] a_ff, b_ff, c_ff, d_ff, init_r_ff, init_f_ff;
   logic [23:0] dt_ff;

   // population state
   logic [31:0] prey_ff, pred_ff, step_ff;

   // working registers
   logic signed [DW-1:0] sr_ff, sf_ff, rf_ff, tmp_ff, kr_ff, kf_ff, sumr_ff, sumf_ff;
   logic [MW-1:0]        a_mag_ff, b_mag_ff, prod_mag_ff;
   logic                 neg_ff, prod_neg_ff;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [DW-1:0]        divr_ff, divf_ff;
   logic                 divr_neg_ff, divf_neg_ff;
   logic [2:0]           remr_ff, remf_ff;

   // result
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_prey_ff, out_pred_ff, out_step_ff;
   logic        out_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff      <= RST_PREY_GROWTH;
         b_ff      <= RST_PREDATION;
         c_ff      <= RST_PREDATOR_GAIN;
         d_ff      <= RST_PREDATOR_DEATH;
         dt_ff     <= RST_TIME_STEP;
         init_r_ff <= RST_INITIAL_PREY;
         init_f_ff <= RST_INITIAL_PRED;
      end else if (csr_we) begin
         case (csr_index)
            REG_PREY_GROWTH:    a_ff      <= csr_wdata;
            REG_PREDATION:      b_ff      <= csr_wdata;
            REG_PREDATOR_GAIN:  c_ff      <= csr_wdata;
            REG_PREDATOR_DEATH: d_ff      <= csr_wdata;
            REG_TIME_STEP:      dt_ff     <= csr_wdata[23:0];
            REG_INITIAL_PREY:   init_r_ff <= csr_wdata;
            REG_INITIAL_PRED:   init_f_ff <= csr_wdata;
            default:            a_ff      <= a_ff;
         endcase
      end
   end

   // operand select
   logic signed [DW-1:0] opnd [12];
   logic signed [DW-1:0] a_val, b_val, neg_a, neg_b;

   always_comb begin
      opnd[OPD_SR]   = sr_ff;
      opnd[OPD_SF]   = sf_ff;
      opnd[OPD_RF]   = rf_ff;
      opnd[OPD_KR]   = kr_ff;
      opnd[OPD_KF]   = kf_ff;
      opnd[OPD_SUMR] = sumr_ff;
      opnd[OPD_SUMF] = sumf_ff;
      opnd[OPD_CA]   = $signed({{(DW-32){1'b0}}, a_ff});
      opnd[OPD_CB]   = $signed({{(DW-32){1'b0}}, b_ff});
      opnd[OPD_CC]   = $signed({{(DW-32){1'b0}}, c_ff});
      opnd[OPD_CD]   = $signed({{(DW-32){1'b0}}, d_ff});
      opnd[OPD_DT]   = $signed({{(DW-24){1'b0}}, dt_ff});
      a_val = opnd[cmd.uop.a_sel];
      b_val = opnd[cmd.uop.b_sel];
      neg_a = -a_val;
      neg_b = -b_val;
   end

   // multiplier: one digit of B per cycle, MSB first
   logic [DIG_W-1:0]       digit;
   logic [MW+DIG_W-1:0]    part;

   always_comb begin
      digit  = b_mag_ff[DIG_W*int'(cmd.dig) +: DIG_W];
      part   = a_mag_ff * digit;
      acc_in = cmd.mul_first ? ACC_W'(part) : (acc_ff << DIG_W) + ACC_W'(part);
   end

   // scale and saturate
   logic [ACC_W-1:0] shifted;
   logic [MW-1:0]    lim;

   always_comb begin
      case (cmd.uop.shift)
         SH_POP:  shifted = acc_ff >> POP_FRAC_BITS;
         SH_COEF: shifted = acc_ff >> COEF_FRAC_BITS;
         SH_HALF: shifted = acc_ff >> (COEF_FRAC_BITS + 1);
         default: shifted = acc_ff >> COEF_FRAC_BITS;
      endcase
      lim = cmd.uop.big ? BIG_LIM : INT_LIM;
   end

   // write-back arithmetic
   logic signed [DW-1:0] prod_s, k_sat, kr_fold, kf_fold;
   logic signed [DW:0]   diff;

   always_comb begin
      prod_s = prod_neg_ff ? -$signed({1'b0, prod_mag_ff}) : $signed({1'b0, prod_mag_ff});
      diff   = {tmp_ff[DW-1], tmp_ff} - {prod_s[DW-1], prod_s};
      if (diff > KLIM_P) begin
         k_sat = KLIM_P[DW-1:0];
      end else if (diff < KLIM_N) begin
         k_sat = KLIM_N[DW-1:0];
      end else begin
         k_sat = diff[DW-1:0];
      end
      kr_fold = cmd.uop.dbl ? (kr_ff <<< 1) : kr_ff;
      kf_fold = cmd.uop.dbl ? (kf_ff <<< 1) : kf_ff;
   end

   // One nibble of a long division by six; the dividend shifts out as the quotient shifts in.
   function automatic logic [DW+2:0] div6_step(input logic [DW-1:0] x, input logic [2:0] rem);
      logic [6:0]  v;
      logic [11:0] scaled;
      logic [3:0]  q;
      logic [6:0]  r;
      v      = {rem, x[DW-1 -: 4]};
      scaled = {5'd0, v} * 12'd43;
      q      = scaled[11:8];
      r      = v - 7'(q) * 7'd6;
      return {r[2:0], x[DW-5:0], q};
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sr_ff   <= $signed({{(DW-32){1'b0}}, prey_ff});
         sf_ff   <= $signed({{(DW-32){1'b0}}, pred_ff});
         sumr_ff <= '0;
         sumf_ff <= '0;
      end
      if (cmd.opnd) begin
         a_mag_ff <= a_val[DW-1] ? neg_a[MW-1:0] : a_val[MW-1:0];
         b_mag_ff <= b_val[DW-1] ? neg_b[MW-1:0] : b_val[MW-1:0];
         neg_ff   <= a_val[DW-1] ^ b_val[DW-1];
      end
      if (cmd.mul) begin
         acc_ff <= acc_in;
      end
      if (cmd.sat) begin
         prod_mag_ff <= (shifted > ACC_W'(lim)) ? lim : shifted[MW-1:0];
         prod_neg_ff <= neg_ff;
      end
      if (cmd.wb) begin
         case (cmd.uop.dst)
            DST_RF:  rf_ff  <= prod_s;
            DST_TMP: tmp_ff <= prod_s;
            DST_KR:  kr_ff  <= k_sat;
            DST_KF:  kf_ff  <= k_sat;
            DST_SR:  sr_ff  <= $signed({{(DW-32){1'b0}}, prey_ff}) + prod_s;
            DST_SF:  sf_ff  <= $signed({{(DW-32){1'b0}}, pred_ff}) + prod_s;
            DST_INCR: begin
               divr_ff     <= {1'b0, prod_mag_ff};
               divr_neg_ff <= prod_neg_ff;
               remr_ff     <= '0;
            end
            DST_INCF: begin
               divf_ff     <= {1'b0, prod_mag_ff};
               divf_neg_ff <= prod_neg_ff;
               remf_ff     <= '0;
            end
            default: rf_ff <= rf_ff;
         endcase
         if (cmd.uop.acc_r) begin
            sumr_ff <= sumr_ff + kr_fold;
         end
         if (cmd.uop.acc_f) begin
            sumf_ff <= sumf_ff + kf_fold;
         end
      end
      if (cmd.div_step) begin
         {remr_ff, divr_ff} <= div6_step(divr_ff, remr_ff);
         {remf_ff, divf_ff} <= div6_step(divf_ff, remf_ff);
      end
   end

   // final add and clamp
   logic signed [DW:0] nr, nf;
   logic [31:0]        nr_pop, nf_pop;
   logic               nr_clip, nf_clip;

   always_comb begin
      nr = divr_neg_ff ? $signed({{(DW-31){1'b0}}, prey_ff}) - $signed({1'b0, divr_ff})
                       : $signed({{(DW-31){1'b0}}, prey_ff}) + $signed({1'b0, divr_ff});
      nf = divf_neg_ff ? $signed({{(DW-31){1'b0}}, pred_ff}) - $signed({1'b0, divf_ff})
                       : $signed({{(DW-31){1'b0}}, pred_ff}) + $signed({1'b0, divf_ff});
      nr_clip = (nr < 0) || (nr > POP_TOP);
      nf_clip = (nf < 0) || (nf > POP_TOP);
      nr_pop  = (nr < 0) ? 32'd0 : ((nr > POP_TOP) ? 32'hFFFF_FFFF : nr[31:0]);
      nf_pop  = (nf < 0) ? 32'd0 : ((nf > POP_TOP) ? 32'hFFFF_FFFF : nf[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prey_ff <= RST_INITIAL_PREY;
         pred_ff <= RST_INITIAL_PRED;
         step_ff <= '0;
      end else if (cmd.accept && restart) begin
         prey_ff <= init_r_ff;
         pred_ff <= init_f_ff;
         step_ff <= '0;
      end else if (cmd.commit) begin
         prey_ff <= nr_pop;
         pred_ff <= nf_pop;
         step_ff <= step_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_prey_ff <= prey_ff;
         out_pred_ff <= pred_ff;
         out_step_ff <= step_ff;
         out_clip_ff <= nr_clip || nf_clip;
      end
   end

   assign stat.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign prey_now      = out_prey_ff;
   assign predator_now  = out_pred_ff;
   assign step_index    = out_step_ff;
   assign clipped       = out_clip_ff;

endmodule

[rtl/core/predator_prey_rk4_step.sv]
// Top level of the Lotka-Volterra RK4 stepper: sequencer plus datapath.
//
// Usage:
//   req_* : one beat per time step. req_tdata[0] = restart, which reloads the
//           initial populations and clears the step index before the step.
//   rsp_* : one beat per request: populations before the step, step index and
//           a flag set when either new population was clamped to 0 .. 2^32-1.
//   csr_* : write enable, register index (0..6) and data; index 7 is ignored.
//           Write only while no step is in flight.
// Sequence: each micro-op of the step runs on the shared multiplier as
//   operand latch, three 17-bit digits, scale/saturate and write-back. A step is
//   28 micro-ops plus a divide by six, a load and a commit, and one request
//   is in flight at a time. req_tready is high only between steps.
// The result register lets the next request start while a result waits. A
//   step that finishes while the old result is still stalled holds in commit
//   until rsp_tready frees the register.
// Reset: configuration goes to its defaults, populations to the initial values,
//   step index to zero, and no result is pending.
module predator_prey_rk4_step #(
   parameter int POP_FRAC_BITS  = 16,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] restart, [7:1] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] prey_now, [63:32] predator_now,
                                     // [95:64] step_index, [96] clipped, rest zero
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import pprk4_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] prey_now, predator_now, step_index;
   logic        clipped;

   pprk4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pprk4_dpath #(
      .POP_FRAC_BITS  (POP_FRAC_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .restart      (req_tdata[0]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .prey_now     (prey_now),
      .predator_now (predator_now),
      .step_index   (step_index),
      .clipped      (clipped)
   );

   // pack the result beat
   assign rsp_tdata = {7'd0, clipped, step_index, predator_now, prey_now};

   // an accepted request closes the input until its step commits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a step is in flight");

   // a commit never overwrites a result that is still stalled
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("commit over a pending result");

   // a commit always produces a result beat
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit without result");

endmodule

[dv/tb_predator_prey_rk4_step.sv]
// Self-checking testbench for the predator-prey RK4 stepper: directed table plus random ticks.
module tb_predator_prey_rk4_step;
   timeunit 1ns;
   timeprecision 1ps;
   import pprk4_pkg::*;

   localparam int TIMEOUT_CYCLES = 1500000;
   localparam longint SAT47 = (64'sd1 <<< 47) - 1;
   // Register index past the end of the map; the block drops the write.
   localparam logic [2:0] REG_NONE = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   predator_prey_rk4_step u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [31:0] prey_now;
      logic [31:0] predator_now;
      logic [31:0] step_index;
      logic        clipped;
   } pop_sample_type;

   // Shadow of the configuration and the population state.
   logic [31:0] coef_a, coef_b, coef_c, coef_d, pop_init_r, pop_init_f;
   logic [23:0] coef_dt;
   logic [31:0] lvl_r, lvl_f, lvl_n;

   pop_sample_type expected_samples[$];
   int  fail_count = 0;
   int  beats_out = 0;
   int  clip_seen = 0;
   int  cycle_count = 0;
   bit  quiet_rsp = 1'b0;   // rsp side never stalls while set

   // Signed product x*y >> sh, truncated toward zero, magnitude clamped to lim.
   function automatic longint mul_trunc(longint x, longint y, int sh, longint lim);
      logic [127:0] p;
      logic [63:0]  mx, my;
      logic         neg;
      neg = (x < 0) != (y < 0);
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      p = ({64'd0, mx} * {64'd0, my}) >> sh;
      if (p > lim) p = lim;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clamp47(longint v);
      if (v > SAT47) return SAT47;
      if (v < -SAT47) return -SAT47;
      return v;
   endfunction

   function automatic void lv_rates(input longint r, input longint f, output longint dr,
                                    output longint df);
      longint rf;
      rf = mul_trunc(r, f, 16, SAT47);
      dr = clamp47(mul_trunc(coef_a, r, 24, SAT47) - mul_trunc(coef_b, rf, 24, SAT47));
      df = clamp47(mul_trunc(coef_c, rf, 24, SAT47) - mul_trunc(coef_d, f, 24, SAT47));
   endfunction

   function automatic void settle_pop(input longint base, input longint sum, inout bit clip,
                                      output logic [31:0] pop);
      longint v;
      v = base + mul_trunc(coef_dt, sum, 24, 64'sd1 <<< 62) / 6;
      if (v < 0) begin
         clip = 1'b1; pop = '0;
      end else if (v > 64'sh0FFFF_FFFF) begin
         clip = 1'b1; pop = '1;
      end else begin
         pop = v[31:0];
      end
   endfunction

   // Predict one tick and advance the shadow state.
   function automatic pop_sample_type rk4_tick(input bit restart);
      pop_sample_type s;
      longint r, f, k1r, k1f, k2r, k2f, k3r, k3f, k4r, k4f;
      bit clip;
      if (restart) begin
         lvl_r = pop_init_r; lvl_f = pop_init_f; lvl_n = '0;
      end
      r = lvl_r; f = lvl_f; clip = 1'b0;
      lv_rates(r, f, k1r, k1f);
      lv_rates(r + mul_trunc(coef_dt, k1r, 25, SAT47),
               f + mul_trunc(coef_dt, k1f, 25, SAT47), k2r, k2f);
      lv_rates(r + mul_trunc(coef_dt, k2r, 25, SAT47),
               f + mul_trunc(coef_dt, k2f, 25, SAT47), k3r, k3f);
      lv_rates(r + mul_trunc(coef_dt, k3r, 24, SAT47),
               f + mul_trunc(coef_dt, k3f, 24, SAT47), k4r, k4f);
      s.prey_now = lvl_r; s.predator_now = lvl_f; s.step_index = lvl_n;
      settle_pop(r, k1r + 2 * k2r + 2 * k3r + k4r, clip, lvl_r);
      settle_pop(f, k1f + 2 * k2f + 2 * k3f + k4f, clip, lvl_f);
      s.clipped = clip;
      lvl_n = lvl_n + 1;
      return s;
   endfunction

   // Busy side idles on about 23 of 100 rolls unless a quiet stretch is on.
   function automatic bit idle_roll(bit quiet);
      return !quiet && ($urandom_range(99) < 23);
   endfunction

   // Result side: random stall, compare each beat with the oldest prediction.
   always @(posedge clock) begin
      pop_sample_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.prey_now     = rsp_tdata[31:0];
            got.predator_now = rsp_tdata[63:32];
            got.step_index   = rsp_tdata[95:64];
            got.clipped      = rsp_tdata[96];
            if (expected_samples.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               beats_out++;
               if (got.clipped) clip_seen++;
               if (got.prey_now !== want.prey_now) begin
                  $error("prey_now exp %0d got %0d", want.prey_now, got.prey_now);
                  fail_count++;
               end
               if (got.predator_now !== want.predator_now) begin
                  $error("predator_now exp %0d got %0d", want.predator_now,
                         got.predator_now);
                  fail_count++;
               end
               if (got.step_index !== want.step_index) begin
                  $error("step_index exp %0d got %0d", want.step_index, got.step_index);
                  fail_count++;
               end
               if (got.clipped !== want.clipped) begin
                  $error("clipped exp %0d got %0d", want.clipped, got.clipped);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !idle_roll(quiet_rsp);
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PREY_GROWTH:    coef_a = val;
         REG_PREDATION:      coef_b = val;
         REG_PREDATOR_GAIN:  coef_c = val;
         REG_PREDATOR_DEATH: coef_d = val;
         REG_TIME_STEP:      coef_dt = val[23:0];
         REG_INITIAL_PREY:   pop_init_r = val;
         REG_INITIAL_PRED:   pop_init_f = val;
         default: ;   // out of range: ignored by the block
      endcase
   endtask

   // Send one tick beat; random gaps before it unless quiet.
   task automatic send_tick(input bit restart, input bit quiet);
      while (idle_roll(quiet)) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      expected_samples.push_back(rk4_tick(restart));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      // step out of this edge; the block is busy for the next step anyway
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Directed rows: restart flag plus a result typed in where it is obvious.
   typedef struct {
      bit             restart;
      bit             has_exp;
      pop_sample_type exp_val;
   } tick_row_type;

   tick_row_type dir_rows[6];

   initial begin
      int n;
      coef_a = RST_PREY_GROWTH; coef_b = RST_PREDATION; coef_c = RST_PREDATOR_GAIN;
      coef_d = RST_PREDATOR_DEATH; coef_dt = RST_TIME_STEP;
      pop_init_r = RST_INITIAL_PREY; pop_init_f = RST_INITIAL_PRED;
      lvl_r = pop_init_r; lvl_f = pop_init_f; lvl_n = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // After reset: defaults, step index zero.
      dir_rows[0] = '{0, 1, '{32'd32768000, 32'd32768000, 32'd0, 1'b0}};
      dir_rows[1] = '{0, 0, '0};
      dir_rows[2] = '{1, 1, '{32'd32768000, 32'd32768000, 32'd0, 1'b0}};
      dir_rows[3] = '{0, 0, '0};
      dir_rows[4] = '{0, 0, '0};
      dir_rows[5] = '{1, 0, '0};
      foreach (dir_rows[i]) begin
         send_tick(dir_rows[i].restart, 1'b0);
         // typed-in rows are checked against the table, the rest against the predictor
         if (dir_rows[i].has_exp) expected_samples[$] = dir_rows[i].exp_val;
      end
      drain_results();

      // Zero coefficients and zero populations: nothing moves.
      csr_write(REG_PREY_GROWTH, '0);   csr_write(REG_PREDATION, '0);
      csr_write(REG_PREDATOR_GAIN, '0); csr_write(REG_PREDATOR_DEATH, '0);
      csr_write(REG_TIME_STEP, '0);
      csr_write(REG_INITIAL_PREY, '0);  csr_write(REG_INITIAL_PRED, '0);
      send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);
      drain_results();

      // All-ones everywhere: saturation on every path, clamp high and low.
      csr_write(REG_PREY_GROWTH, '1);   csr_write(REG_PREDATION, '1);
      csr_write(REG_PREDATOR_GAIN, '1); csr_write(REG_PREDATOR_DEATH, '1);
      csr_write(REG_TIME_STEP, '1);
      csr_write(REG_INITIAL_PREY, '1);  csr_write(REG_INITIAL_PRED, '1);
      csr_write(REG_NONE, 32'h1234_5678);   // out of range, dropped
      for (int i = 0; i < 4; i++) send_tick(i == 0, 1'b0);
      drain_results();

      // Strong growth, no predation: prey clamps at the top.
      csr_write(REG_PREY_GROWTH, 32'hFF00_0000); csr_write(REG_PREDATION, '0);
      csr_write(REG_PREDATOR_DEATH, 32'hFF00_0000); csr_write(REG_PREDATOR_GAIN, '0);
      csr_write(REG_INITIAL_PREY, 32'h8000_0000); csr_write(REG_INITIAL_PRED, 32'h0001_0000);
      for (int i = 0; i < 4; i++) send_tick(i == 0, 1'b0);
      drain_results();

      // Random phases: new settings each phase, mostly long runs, some restarts.
      n = 0;
      while (n < 1700) begin
         int run_len;
         case ($urandom_range(3))
            0: begin
               csr_write(REG_PREY_GROWTH, RST_PREY_GROWTH);
               csr_write(REG_PREDATION, RST_PREDATION);
               csr_write(REG_PREDATOR_GAIN, RST_PREDATOR_GAIN);
               csr_write(REG_PREDATOR_DEATH, RST_PREDATOR_DEATH);
               csr_write(REG_TIME_STEP, $urandom());
            end
            1: begin
               csr_write(REG_PREY_GROWTH, $urandom_range(32'h0400_0000));
               csr_write(REG_PREDATION, $urandom_range(32'h0010_0000));
               csr_write(REG_PREDATOR_GAIN, $urandom_range(32'h0010_0000));
               csr_write(REG_PREDATOR_DEATH, $urandom_range(32'h0400_0000));
               csr_write(REG_TIME_STEP, $urandom_range(24'hFF_FFFF));
            end
            default: begin
               csr_write(REG_PREY_GROWTH, $urandom());
               csr_write(REG_PREDATION, $urandom());
               csr_write(REG_PREDATOR_GAIN, $urandom());
               csr_write(REG_PREDATOR_DEATH, $urandom());
               csr_write(REG_TIME_STEP, $urandom());
            end
         endcase
         csr_write(REG_INITIAL_PREY, $urandom());
         csr_write(REG_INITIAL_PRED, $urandom());
         if ($urandom_range(7) == 0) csr_write(REG_NONE, $urandom());
         quiet_rsp = ($urandom_range(5) == 0);
         run_len = $urandom_range(10, 40);
         for (int i = 0; i < run_len; i++) begin
            send_tick(i == 0 || $urandom_range(15) == 0, quiet_rsp);
            n++;
            // Hold off until the pipe empties, now and then.
            if ($urandom_range(30) == 0) begin
               while (expected_samples.size() != 0) @(posedge clock);
            end
         end
         drain_results();
      end
      quiet_rsp = 1'b0;

      drain_results();
      $display("covered %0d result beats, %0d clipped, over reset, zero, all-ones", beats_out,
               clip_seen);
      $display("and random coefficient phases with restarts and back-pressure");
      if (fail_count == 0 && expected_samples.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
